// ===== hdl/ortt_pkg.sv =====
package ortt_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SIDX_W      = IDX_W + 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 5) ? CNT_W : 5;
    localparam int QDEPTH      = TABLE_DEPTH + 1;
    localparam int QPTR_W      = $clog2(QDEPTH + 1);
    localparam int QIDX_W      = $clog2(QDEPTH);

    // Operation codes
    localparam logic [2:0] OP_SEND     = 3'd0;
    localparam logic [2:0] OP_RESPONSE = 3'd1;
    localparam logic [2:0] OP_CANCEL   = 3'd2;
    localparam logic [2:0] OP_TICK     = 3'd3;
    localparam logic [2:0] OP_START    = 3'd4;
    localparam logic [2:0] OP_STOP     = 3'd5;

    // Result kinds
    localparam logic [2:0] KIND_SENT      = 3'd0;
    localparam logic [2:0] KIND_RESENT    = 3'd1;
    localparam logic [2:0] KIND_COMPLETED = 3'd2;
    localparam logic [2:0] KIND_FAILED    = 3'd3;
    localparam logic [2:0] KIND_SUMMARY   = 3'd4;

    // Status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_SHUTDOWN  = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_CANCELLED = 3'd3;
    localparam logic [2:0] STAT_TIMEOUT   = 3'd4;
    localparam logic [2:0] STAT_DUPLICATE = 3'd5;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd6;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEFAULT_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_RETRY   = 2'd1;
    localparam logic [1:0] CFG_MAX_PENDING     = 2'd2;

    // One table entry as held in memory
    typedef struct packed {
        logic [15:0] txn;
        logic [31:0] handle;
        logic [15:0] timeout;
        logic [15:0] elapsed;
        logic [3:0]  retries;
        logic [3:0]  retry_limit;
    } t_entry;

    // One result before the pending count and last flag are attached
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [15:0] txn;
        logic [31:0] handle;
        logic [15:0] latency;
        logic [3:0]  attempt;
    } t_res;

endpackage

// ===== hdl/outstanding_request_retry_table.sv =====
// Refused sends, start, unknown ops, and tick or stop while stopped queue their single result
// at accept; ops that sweep the table (other sends, response, cancel, and tick or stop while
// running) queue their results during the sweep and present them after it ends.
// Throughput: one item at a time; the sweep through the entry memory (one slot read per cycle,
// written back on a tick) sets the rate; results drain at one per cycle while the receiver is ready.
// Reset (i_rst_n low, synchronous): block stopped, table empty, registers at defaults.
module outstanding_request_retry_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // txn_id[15:0], request_handle[47:16],
                                       // timeout_ticks[63:48], retry_limit[68:64],
                                       // zero[71:69]
    input  logic [2:0]  s_axis_tuser,  // op[2:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // status[2:0], out_txn_id[18:3], out_handle[50:19],
                                       // latency[66:51], attempt[70:67],
                                       // pending_count[75:71], zero[79:76]
    output logic [2:0]  m_axis_tuser,  // kind[2:0]
    output logic        m_axis_tlast
);
    import ortt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FIN   = 4'b0100,
        S_DRAIN = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [15:0] r_def_tmo;
    logic [3:0]  r_def_rl;
    logic [4:0]  r_max_pend;

    // control state
    logic                   r_running, n_running;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [SIDX_W-1:0]      r_sidx, n_sidx;
    logic                   r_pv, n_pv;
    logic [IDX_W-1:0]       r_pidx;
    logic                   r_found, n_found;

    // latched item
    logic [2:0]       r_op;
    logic [15:0]      r_txn;
    logic [31:0]      r_handle;
    logic [15:0]      r_tmo;
    logic [3:0]       r_rl;
    logic [IDX_W-1:0] r_free;

    // entry memory
    t_entry           mem [TABLE_DEPTH];
    t_entry           r_rdata;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    t_entry           mem_wdata;
    logic             rd_en;

    // result queue and output register
    logic   q_clear, q_push, q_pop, q_empty, q_last;
    t_res   q_wdata, q_rdata;
    logic   r_ovalid;
    t_res   r_ores;
    logic   r_olast;
    logic [CNT_W-1:0] r_opc;

    // input fields
    logic [2:0]  in_op;
    logic [15:0] in_txn;
    logic [31:0] in_handle;
    logic [15:0] in_tmo;
    logic [4:0]  in_rl;
    assign in_op     = s_axis_tuser;
    assign in_txn    = s_axis_tdata[15:0];
    assign in_handle = s_axis_tdata[47:16];
    assign in_tmo    = s_axis_tdata[63:48];
    assign in_rl     = s_axis_tdata[68:64];

    logic accept;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    // effective queue limit, capped at the table depth
    logic [CMP_W-1:0] limit;
    always_comb begin
        if (CMP_W'(r_max_pend) < CMP_W'(TABLE_DEPTH)) limit = CMP_W'(r_max_pend);
        else                                           limit = CMP_W'(TABLE_DEPTH);
    end

    // lowest free slot
    logic [IDX_W-1:0] free_idx;
    always_comb begin
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = IDX_W'(i);
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_tmo  <= 16'd10;
            r_def_rl   <= 4'd2;
            r_max_pend <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEFAULT_TIMEOUT: r_def_tmo  <= i_cfg_data;
                CFG_DEFAULT_RETRY:   r_def_rl   <= i_cfg_data[3:0];
                CFG_MAX_PENDING:     r_max_pend <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // latch the accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= in_op;
            r_txn    <= in_txn;
            r_handle <= in_handle;
            r_tmo    <= (in_tmo == 16'd0) ? r_def_tmo : in_tmo;
            r_rl     <= in_rl[4] ? r_def_rl : in_rl[3:0];
            r_free   <= free_idx;
        end
    end

    // entry memory, registered read port
    assign rd_en = (r_state == S_SCAN) && (r_sidx < SIDX_W'(TABLE_DEPTH));
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (rd_en)  r_rdata <= mem[r_sidx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_pidx <= r_sidx[IDX_W-1:0];
    end

    // main sequencer
    logic        pv_valid;
    logic [15:0] elapsed_inc;
    assign pv_valid    = r_pv && r_valid[r_pidx];
    assign elapsed_inc = (r_rdata.elapsed == 16'hFFFF) ? 16'hFFFF : r_rdata.elapsed + 16'd1;

    always_comb begin
        n_state   = r_state;
        n_running = r_running;
        n_valid   = r_valid;
        n_count   = r_count;
        n_sidx    = r_sidx;
        n_pv      = 1'b0;
        n_found   = r_found;
        mem_we    = 1'b0;
        mem_waddr = r_pidx;
        mem_wdata = r_rdata;
        q_clear   = 1'b0;
        q_push    = 1'b0;
        q_wdata   = '{kind: KIND_SUMMARY, status: STAT_OK, txn: '0, handle: '0,
                      latency: '0, attempt: '0};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    q_clear = 1'b1;
                    n_sidx  = '0;
                    n_found = 1'b0;
                    n_state = S_DRAIN;
                    case (in_op)
                        OP_SEND: begin
                            q_wdata.kind   = KIND_FAILED;
                            q_wdata.txn    = in_txn;
                            q_wdata.handle = in_handle;
                            if (!r_running) begin
                                q_wdata.status = STAT_SHUTDOWN;
                                q_push         = 1'b1;
                            end else if (CMP_W'(r_count) >= limit) begin
                                q_wdata.status = STAT_FULL;
                                q_push         = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_RESPONSE, OP_CANCEL: n_state = S_SCAN;
                        OP_TICK, OP_STOP: begin
                            if (r_running) n_state = S_SCAN;
                            else           q_push  = 1'b1;
                        end
                        OP_START: begin
                            n_running = 1'b1;
                            q_push    = 1'b1;
                        end
                        default: q_push = 1'b1;
                    endcase
                end
            end

            S_SCAN: begin
                if (rd_en) begin
                    n_sidx = r_sidx + 1'b1;
                    n_pv   = 1'b1;
                end
                // work on the slot read last cycle
                if (pv_valid) begin
                    q_wdata.txn     = r_rdata.txn;
                    q_wdata.handle  = r_rdata.handle;
                    q_wdata.attempt = r_rdata.retries;
                    case (r_op)
                        OP_SEND: begin
                            if (r_rdata.txn == r_txn) n_found = 1'b1;
                        end
                        OP_RESPONSE, OP_CANCEL: begin
                            if (r_rdata.txn == r_txn && !r_found) begin
                                n_found          = 1'b1;
                                n_valid[r_pidx]  = 1'b0;
                                n_count          = r_count - 1'b1;
                                q_push           = 1'b1;
                                if (r_op == OP_RESPONSE) begin
                                    q_wdata.kind    = KIND_COMPLETED;
                                    q_wdata.latency = r_rdata.elapsed;
                                end else begin
                                    q_wdata.kind   = KIND_FAILED;
                                    q_wdata.status = STAT_CANCELLED;
                                end
                            end
                        end
                        OP_TICK: begin
                            mem_we = 1'b1;
                            mem_wdata.elapsed = elapsed_inc;
                            if (elapsed_inc >= r_rdata.timeout) begin
                                q_push = 1'b1;
                                if (r_rdata.retries < r_rdata.retry_limit) begin
                                    mem_wdata.retries = r_rdata.retries + 4'd1;
                                    mem_wdata.elapsed = 16'd0;
                                    q_wdata.kind      = KIND_RESENT;
                                    q_wdata.attempt   = r_rdata.retries + 4'd1;
                                end else begin
                                    n_valid[r_pidx] = 1'b0;
                                    n_count         = r_count - 1'b1;
                                    q_wdata.kind    = KIND_FAILED;
                                    q_wdata.status  = STAT_TIMEOUT;
                                end
                            end
                        end
                        OP_STOP: begin
                            n_valid[r_pidx] = 1'b0;
                            n_count         = r_count - 1'b1;
                            q_push          = 1'b1;
                            q_wdata.kind    = KIND_FAILED;
                            q_wdata.status  = STAT_SHUTDOWN;
                        end
                        default: ;
                    endcase
                end
                if (!rd_en && !r_pv) n_state = S_FIN;
            end

            S_FIN: begin
                n_state = S_DRAIN;
                case (r_op)
                    OP_SEND: begin
                        q_push         = 1'b1;
                        q_wdata.txn    = r_txn;
                        q_wdata.handle = r_handle;
                        if (r_found) begin
                            q_wdata.kind   = KIND_FAILED;
                            q_wdata.status = STAT_DUPLICATE;
                        end else begin
                            q_wdata.kind    = KIND_SENT;
                            mem_we          = 1'b1;
                            mem_waddr       = r_free;
                            mem_wdata       = '{txn: r_txn, handle: r_handle, timeout: r_tmo,
                                                elapsed: '0, retries: '0, retry_limit: r_rl};
                            n_valid[r_free] = 1'b1;
                            n_count         = r_count + 1'b1;
                        end
                    end
                    OP_RESPONSE, OP_CANCEL: begin
                        if (!r_found) begin
                            q_push         = 1'b1;
                            q_wdata.status = STAT_NOT_FOUND;
                        end
                    end
                    OP_STOP: begin
                        n_running = 1'b0;
                        q_push    = 1'b1;
                    end
                    default: q_push = 1'b1;
                endcase
            end

            S_DRAIN: begin
                if (q_empty) n_state = S_IDLE;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
            r_sidx    <= '0;
            r_pv      <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_sidx    <= n_sidx;
            r_pv      <= n_pv;
            r_found   <= n_found;
        end
    end

    // result queue: results wait here until the final pending count is known
    ortt_res_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (q_clear),
        .i_push     (q_push),
        .i_data     (q_wdata),
        .i_pop      (q_pop),
        .o_data     (q_rdata),
        .o_empty    (q_empty),
        .o_last_one (q_last)
    );

    // output register
    logic out_free;
    assign out_free = !r_ovalid || m_axis_tready;
    assign q_pop    = (r_state == S_DRAIN) && out_free && !q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (q_pop) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_ores  <= q_rdata;
            r_olast <= q_last;
            r_opc   <= r_count;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_ores.kind;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {4'd0, 5'(r_opc), r_ores.attempt, r_ores.latency,
                            r_ores.handle, r_ores.txn, r_ores.status};

endmodule

// ===== hdl/ortt_res_queue.sv =====
module ortt_res_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clear,
    input  logic            i_push,
    input  ortt_pkg::t_res  i_data,
    input  logic            i_pop,
    output ortt_pkg::t_res  o_data,
    output logic            o_empty,
    output logic            o_last_one
);
    import ortt_pkg::*;

    t_res              r_buf [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QIDX_W-1:0] wr_addr;

    // a push in the clearing cycle lands in the first slot
    assign wr_addr = i_clear ? '0 : r_wr[QIDX_W-1:0];

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else if (i_clear) begin
            r_wr <= QPTR_W'(i_push);
            r_rd <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[wr_addr] <= i_data;
    end

    assign o_data     = r_buf[r_rd[QIDX_W-1:0]];
    assign o_empty    = (r_rd == r_wr);
    assign o_last_one = (r_rd + 1'b1 == r_wr);

endmodule

// ===== dv/outstanding_request_retry_table_test.sv =====
module outstanding_request_retry_table_test;
    import ortt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One request-side transaction, unpacked
    typedef struct {
        logic [2:0]  op;
        logic [15:0] txn;
        logic [31:0] handle;
        logic [15:0] tmo;
        logic [4:0]  rl;
    } t_req;

    // One expected result, unpacked
    typedef struct {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [15:0] txn;
        logic [31:0] handle;
        logic [15:0] latency;
        logic [3:0]  attempt;
        logic [4:0]  pend;
        logic        last;
    } t_outcome;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    outstanding_request_retry_table dut (.*);

    // Predictor state: table copy and registers
    logic        tbl_valid [TABLE_DEPTH];
    t_entry      tbl       [TABLE_DEPTH];
    logic        tbl_running;
    logic [15:0] reg_timeout;
    logic [3:0]  reg_retry;
    logic [4:0]  reg_max_pending;

    t_req     pending_reqs[$];
    t_outcome expected_results[$];
    int       error_count;
    int       accepted_count;
    int       sent_count;
    int       result_count;
    int       stall_hold;
    int       sender_gap;
    int       receiver_gap;
    logic [15:0] live_ids[$];

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic queue_req(input t_req r);
        pending_reqs = {pending_reqs, r};
    endtask

    function automatic int pending_entries();
        int c;
        c = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) if (tbl_valid[i]) c++;
        return c;
    endfunction

    function automatic int find_slot(input logic [15:0] id);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (tbl_valid[i] && tbl[i].txn == id) return i;
        return -1;
    endfunction

    // Work out the results of one accepted request and update the table copy
    task automatic predict_table_op(input t_req r);
        t_outcome res[$];
        t_outcome o;
        int slot;
        int cap;
        int pc;
        o = '{default: '0};
        cap = (reg_max_pending < TABLE_DEPTH) ? reg_max_pending : TABLE_DEPTH;
        case (r.op)
            OP_SEND: begin
                o.kind = KIND_FAILED; o.txn = r.txn; o.handle = r.handle;
                slot = -1;
                for (int i = TABLE_DEPTH - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
                if (!tbl_running) o.status = STAT_SHUTDOWN;
                else if (pending_entries() >= cap || slot < 0) o.status = STAT_FULL;
                else if (find_slot(r.txn) >= 0) o.status = STAT_DUPLICATE;
                else begin
                    tbl_valid[slot] = 1'b1;
                    tbl[slot].txn = r.txn;
                    tbl[slot].handle = r.handle;
                    tbl[slot].timeout = (r.tmo == 0) ? reg_timeout : r.tmo;
                    tbl[slot].retry_limit = r.rl[4] ? reg_retry : r.rl[3:0];
                    tbl[slot].elapsed = '0;
                    tbl[slot].retries = '0;
                    o.kind = KIND_SENT; o.status = STAT_OK;
                end
                res = {res, o};
            end
            OP_RESPONSE, OP_CANCEL: begin
                slot = find_slot(r.txn);
                if (slot < 0) begin
                    o.kind = KIND_SUMMARY; o.status = STAT_NOT_FOUND;
                end else begin
                    tbl_valid[slot] = 1'b0;
                    o.txn = tbl[slot].txn; o.handle = tbl[slot].handle;
                    o.attempt = tbl[slot].retries;
                    if (r.op == OP_RESPONSE) begin
                        o.kind = KIND_COMPLETED; o.status = STAT_OK;
                        o.latency = tbl[slot].elapsed;
                    end else begin
                        o.kind = KIND_FAILED; o.status = STAT_CANCELLED;
                    end
                end
                res = {res, o};
            end
            OP_TICK: begin
                if (tbl_running) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (!tbl_valid[i]) continue;
                        if (tbl[i].elapsed != 16'hFFFF) tbl[i].elapsed++;
                        if (tbl[i].elapsed < tbl[i].timeout) continue;
                        o = '{default: '0};
                        o.txn = tbl[i].txn; o.handle = tbl[i].handle;
                        if (tbl[i].retries < tbl[i].retry_limit) begin
                            tbl[i].retries++;
                            tbl[i].elapsed = '0;
                            o.kind = KIND_RESENT; o.status = STAT_OK;
                        end else begin
                            tbl_valid[i] = 1'b0;
                            o.kind = KIND_FAILED; o.status = STAT_TIMEOUT;
                        end
                        o.attempt = tbl[i].retries;
                        res = {res, o};
                    end
                end
                o = '{default: '0}; o.kind = KIND_SUMMARY;
                res = {res, o};
            end
            OP_STOP: begin
                if (tbl_running) begin
                    tbl_running = 1'b0;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (!tbl_valid[i]) continue;
                        tbl_valid[i] = 1'b0;
                        o = '{default: '0};
                        o.kind = KIND_FAILED; o.status = STAT_SHUTDOWN;
                        o.txn = tbl[i].txn; o.handle = tbl[i].handle;
                        o.attempt = tbl[i].retries;
                        res = {res, o};
                    end
                end
                o = '{default: '0}; o.kind = KIND_SUMMARY;
                res = {res, o};
            end
            default: begin
                if (r.op == OP_START) tbl_running = 1'b1;
                o.kind = KIND_SUMMARY;
                res = {res, o};
            end
        endcase
        pc = pending_entries();
        foreach (res[k]) begin
            res[k].pend = pc[4:0];
            res[k].last = (k == res.size() - 1);
            expected_results = {expected_results, res[k]};
        end
    endtask

    // Driver: presents queued requests, inserts random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && accepted_count < sent_count) begin
            // hold the offered transaction until it is taken
        end else if (sender_gap > 0) begin
            sender_gap <= sender_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            t_req r;
            r = pending_reqs.pop_front();
            s_axis_tdata <= {3'd0, r.rl, r.tmo, r.handle, r.txn};
            s_axis_tuser <= r.op;
            s_axis_tvalid <= 1'b1;
            sent_count <= sent_count + 1;
            sender_gap <= ($urandom_range(0, 9) < 6) ? 0 :
                          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                          $urandom_range(10, 40);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver back-pressure, with an occasional long hold-off
    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (receiver_gap > 0) begin
            receiver_gap <= receiver_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 9) < 3)
                receiver_gap <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) :
                                $urandom_range(8, 30);
        end
    end

    // Monitor: predict on accepted requests, check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                t_req r;
                r.op = s_axis_tuser;
                r.txn = s_axis_tdata[15:0];
                r.handle = s_axis_tdata[47:16];
                r.tmo = s_axis_tdata[63:48];
                r.rl = s_axis_tdata[68:64];
                predict_table_op(r);
                accepted_count++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                t_outcome e;
                result_count++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_results.pop_front();
                    if (m_axis_tuser != e.kind)
                        report_mismatch($sformatf("kind %0d exp %0d", m_axis_tuser, e.kind));
                    if (m_axis_tdata[2:0] != e.status)
                        report_mismatch($sformatf("status %0d exp %0d",
                                                  m_axis_tdata[2:0], e.status));
                    if (m_axis_tdata[18:3] != e.txn)
                        report_mismatch($sformatf("txn %h exp %h", m_axis_tdata[18:3], e.txn));
                    if (m_axis_tdata[50:19] != e.handle)
                        report_mismatch($sformatf("handle %h exp %h",
                                                  m_axis_tdata[50:19], e.handle));
                    if (m_axis_tdata[66:51] != e.latency)
                        report_mismatch($sformatf("latency %0d exp %0d",
                                                  m_axis_tdata[66:51], e.latency));
                    if (m_axis_tdata[70:67] != e.attempt)
                        report_mismatch($sformatf("attempt %0d exp %0d",
                                                  m_axis_tdata[70:67], e.attempt));
                    if (m_axis_tdata[75:71] != e.pend)
                        report_mismatch($sformatf("pending %0d exp %0d",
                                                  m_axis_tdata[75:71], e.pend));
                    if (m_axis_tdata[79:76] != 4'd0)
                        report_mismatch("padding bits not zero");
                    if (m_axis_tlast != e.last)
                        report_mismatch($sformatf("last %0b exp %0b", m_axis_tlast, e.last));
                end
            end
        end
    end

    function automatic t_req mk(input logic [2:0] op, input logic [15:0] id,
                                input logic [31:0] h, input logic [15:0] tmo,
                                input logic [4:0] rl);
        t_req r;
        r.op = op; r.txn = id; r.handle = h; r.tmo = tmo; r.rl = rl;
        return r;
    endfunction

    // Random request biased toward live ids so responses and cancels hit
    function automatic t_req random_req(input int max_id);
        t_req r;
        int pick;
        r.handle = $urandom();
        r.txn = (max_id < 0) ? 16'($urandom()) : 16'($urandom_range(0, max_id));
        r.tmo = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 6)) : 16'($urandom());
        r.rl = ($urandom_range(0, 3) == 0) ? 5'(5'h10 | $urandom_range(0, 15)) :
               5'($urandom_range(0, 4));
        pick = $urandom_range(0, 99);
        if (pick < 35) r.op = OP_SEND;
        else if (pick < 50) r.op = OP_RESPONSE;
        else if (pick < 58) r.op = OP_CANCEL;
        else if (pick < 88) r.op = OP_TICK;
        else if (pick < 93) r.op = OP_START;
        else if (pick < 97) r.op = OP_STOP;
        else r.op = 3'($urandom_range(6, 7));
        if ((r.op == OP_RESPONSE || r.op == OP_CANCEL) && live_ids.size() > 0 &&
            $urandom_range(0, 9) < 8)
            r.txn = live_ids[$urandom_range(0, live_ids.size() - 1)];
        if (r.op == OP_SEND) live_ids = {live_ids, r.txn};
        if (live_ids.size() > 40) void'(live_ids.pop_front());
        return r;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_DEFAULT_TIMEOUT: reg_timeout = val;
            CFG_DEFAULT_RETRY:   reg_retry = val[3:0];
            CFG_MAX_PENDING:     reg_max_pending = val[4:0];
            default: ;
        endcase
    endtask

    // Let the block drain fully before touching registers
    task automatic wait_idle();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 10) @(posedge i_clk);
    endtask

    initial begin
        int phase_cfg[4][3];
        error_count = 0; accepted_count = 0; sent_count = 0; result_count = 0;
        stall_hold = 0; sender_gap = 0; receiver_gap = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0; m_axis_tready = 1'b0;
        tbl_running = 1'b0; reg_timeout = 16'd10; reg_retry = 4'd2;
        reg_max_pending = 5'd16;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            tbl_valid[i] = 1'b0; tbl[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: refusals while stopped, field extremes, each op and corner
        queue_req(mk(OP_SEND, 16'h1234, 32'hFFFF_FFFF, '0, 5'h1F));
        queue_req(mk(OP_TICK, '0, '0, '0, '0));
        queue_req(mk(OP_STOP, '0, '0, '0, '0));
        queue_req(mk(OP_START, '0, '0, '0, '0));
        queue_req(mk(OP_START, '0, '0, '0, '0));
        queue_req(mk(OP_SEND, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'h0F));
        queue_req(mk(OP_SEND, 16'h0000, 32'h0, 16'd1, 5'h00));
        queue_req(mk(OP_SEND, 16'hFFFF, 32'h5A5A_A5A5, 16'd1, 5'h00));
        queue_req(mk(OP_SEND, 16'h00AA, 32'hA5A5_5A5A, '0, 5'h10));
        queue_req(mk(OP_SEND, 16'h0055, 32'h1, 16'd2, 5'd1));
        queue_req(mk(OP_TICK, '0, '0, '0, '0));
        queue_req(mk(OP_TICK, '0, '0, '0, '0));
        queue_req(mk(OP_RESPONSE, 16'h0055, '0, '0, '0));
        queue_req(mk(OP_CANCEL, 16'h00AA, '0, '0, '0));
        queue_req(mk(OP_RESPONSE, 16'h7777, '0, '0, '0));
        queue_req(mk(OP_CANCEL, 16'h7777, '0, '0, '0));
        queue_req(mk(3'd6, '0, '0, '0, '0));
        queue_req(mk(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 5'h1F));
        for (int i = 0; i < 16; i++)
            queue_req(mk(OP_SEND, 16'(i + 16'h100), $urandom(), 16'd3, 5'h1F));
        queue_req(mk(OP_STOP, '0, '0, '0, '0));
        queue_req(mk(OP_RESPONSE, 16'hFFFF, '0, '0, '0));
        wait_idle();

        // Register phases: extremes first, then mid values
        phase_cfg = '{'{0, 0, 0}, '{1, 15, 1}, '{65535, 0, 16}, '{3, 1, 4}};
        for (int p = 0; p < 4; p++) begin
            write_reg(CFG_DEFAULT_TIMEOUT, 16'(phase_cfg[p][0]));
            write_reg(CFG_DEFAULT_RETRY, 16'(phase_cfg[p][1]));
            write_reg(CFG_MAX_PENDING, 16'(phase_cfg[p][2]));
            write_reg(2'd3, 16'hFFFF);
            queue_req(mk(OP_START, '0, '0, '0, '0));
            for (int i = 0; i < 80; i++)
                queue_req(random_req((p == 2) ? -1 : 40));
            if (p == 1) begin
                // Hold the receiver off while sends and ticks keep coming
                stall_hold = 300;
                for (int i = 0; i < 30; i++)
                    queue_req(mk((i % 3 == 0) ? OP_TICK : OP_SEND,
                                 16'(i + 16'h300), $urandom(), '0, 5'h1F));
            end
            queue_req(mk(OP_STOP, '0, '0, '0, '0));
            wait_idle();
        end

        $display("covered %0d requests and %0d results over 4 register settings",
                 accepted_count, result_count);
        $display("including duplicates, refusals, timeouts, retries and shutdowns");
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
